// ----- rtl/core/pssu_pkg.sv -----
// Shared types and constants for the pendulum swing-up sequencer.
// Used by every module in rtl/core; depends on nothing.
package pssu_pkg;

	localparam int ANGLE_W = 12;
	localparam int RANGE_W = 11;
	localparam int DRIVE_W = 7;
	localparam int COUNT_W = 16;
	localparam int PHASE_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int BAND_W = 14;

	localparam logic [CFG_INDEX_W-1:0] CFG_UPRIGHT_ANGLE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_RANGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KICK_DRIVE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KICK_TICKS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DIVIDER = 3'd4;

	localparam logic [ANGLE_W-1:0] RST_UPRIGHT_ANGLE = 12'd2025;
	localparam logic [RANGE_W-1:0] RST_CAPTURE_RANGE = 11'd500;
	localparam logic [DRIVE_W-1:0] RST_KICK_DRIVE = 7'd35;
	localparam logic [COUNT_W-1:0] RST_KICK_TICKS = 16'd100;
	localparam logic [COUNT_W-1:0] RST_SAMPLE_DIVIDER = 16'd40;

	localparam logic [DRIVE_W-1:0] DRIVE_LIMIT = 7'd100;

	localparam logic [PHASE_W-1:0] PH_STOP = 4'd0;
	localparam logic [PHASE_W-1:0] PH_WAIT = 4'd1;
	localparam logic [PHASE_W-1:0] PH_POS_LOAD_A = 4'd2;
	localparam logic [PHASE_W-1:0] PH_POS_HOLD_A = 4'd3;
	localparam logic [PHASE_W-1:0] PH_POS_LOAD_B = 4'd4;
	localparam logic [PHASE_W-1:0] PH_POS_HOLD_B = 4'd5;
	localparam logic [PHASE_W-1:0] PH_NEG_LOAD_A = 4'd6;
	localparam logic [PHASE_W-1:0] PH_NEG_HOLD_A = 4'd7;
	localparam logic [PHASE_W-1:0] PH_NEG_LOAD_B = 4'd8;
	localparam logic [PHASE_W-1:0] PH_NEG_HOLD_B = 4'd9;
	localparam logic [PHASE_W-1:0] PH_BALANCE = 4'd10;

	typedef struct packed {
		logic mode;
		logic [ANGLE_W-1:0] angle_sample;
	} in_item_t;

	typedef struct packed {
		logic drive_write;
		logic signed [7:0] drive_value;
		logic [PHASE_W-1:0] phase_code;
		logic balance_active;
		logic balance_clear;
	} out_item_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] upright_angle;
		logic [RANGE_W-1:0] capture_range;
		logic [DRIVE_W-1:0] kick_drive;
		logic [COUNT_W-1:0] kick_ticks;
		logic [COUNT_W-1:0] sample_divider;
	} cfg_t;

endpackage

// ----- rtl/core/pssu_cfg_regs.sv -----
// Configuration register file of the pendulum swing-up sequencer.
// Depends on pssu_pkg for the register indexes, widths and reset values.
module pssu_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_en,
	input  logic [pssu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pssu_pkg::CFG_DATA_W-1:0] cfg_data,
	output pssu_pkg::cfg_t cfg
);

	pssu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upright_angle <= pssu_pkg::RST_UPRIGHT_ANGLE;
			cfg_q.capture_range <= pssu_pkg::RST_CAPTURE_RANGE;
			cfg_q.kick_drive <= pssu_pkg::RST_KICK_DRIVE;
			cfg_q.kick_ticks <= pssu_pkg::RST_KICK_TICKS;
			cfg_q.sample_divider <= pssu_pkg::RST_SAMPLE_DIVIDER;
		end else if (cfg_write_en) begin
			case (cfg_index)
				pssu_pkg::CFG_UPRIGHT_ANGLE: begin
					cfg_q.upright_angle <= cfg_data[pssu_pkg::ANGLE_W-1:0];
				end
				pssu_pkg::CFG_CAPTURE_RANGE: begin
					cfg_q.capture_range <= cfg_data[pssu_pkg::RANGE_W-1:0];
				end
				pssu_pkg::CFG_KICK_DRIVE: begin
					cfg_q.kick_drive <= cfg_data[pssu_pkg::DRIVE_W-1:0];
				end
				pssu_pkg::CFG_KICK_TICKS: begin
					cfg_q.kick_ticks <= cfg_data[pssu_pkg::COUNT_W-1:0];
				end
				pssu_pkg::CFG_SAMPLE_DIVIDER: begin
					cfg_q.sample_divider <= cfg_data[pssu_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/pssu_core.sv -----
// Phase state, counters and angle history of the swing-up sequencer, with
// the logic that works out one item's result. Depends on pssu_pkg.
module pssu_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  pssu_pkg::in_item_t item,
	input  pssu_pkg::cfg_t cfg,
	output pssu_pkg::out_item_t result
);

	logic [pssu_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [pssu_pkg::COUNT_W-1:0] dec_count_q, dec_count_d;
	logic [pssu_pkg::COUNT_W-1:0] kick_count_q, kick_count_d;
	logic [pssu_pkg::ANGLE_W-1:0] hist_q [3];
	logic hist_shift;

	logic signed [pssu_pkg::BAND_W-1:0] band_hi, band_lo;
	logic signed [pssu_pkg::BAND_W-1:0] a0, a1, a2;
	logic [pssu_pkg::DRIVE_W-1:0] kick_mag;
	logic signed [7:0] kick_pos, kick_neg;
	logic [pssu_pkg::COUNT_W-1:0] dec_inc, kick_dec;
	logic wr, clr;
	logic signed [7:0] dv;

	always_comb begin
		band_hi = $signed({2'b00, cfg.upright_angle})
			+ $signed({3'b000, cfg.capture_range});
		band_lo = $signed({2'b00, cfg.upright_angle})
			- $signed({3'b000, cfg.capture_range});
		a0 = $signed({2'b00, item.angle_sample});
		a1 = $signed({2'b00, hist_q[0]});
		a2 = $signed({2'b00, hist_q[1]});
		kick_mag = (cfg.kick_drive > pssu_pkg::DRIVE_LIMIT) ? pssu_pkg::DRIVE_LIMIT
			: cfg.kick_drive;
		kick_pos = $signed({1'b0, kick_mag});
		kick_neg = -kick_pos;
		dec_inc = dec_count_q + 1'b1;
		kick_dec = kick_count_q - 1'b1;

		phase_d = phase_q;
		dec_count_d = dec_count_q;
		kick_count_d = kick_count_q;
		hist_shift = 1'b0;
		wr = 1'b0;
		dv = '0;
		clr = 1'b0;

		if (item.mode) begin
			phase_d = (phase_q == pssu_pkg::PH_STOP) ? pssu_pkg::PH_POS_LOAD_A
				: pssu_pkg::PH_STOP;
		end else begin
			case (phase_q)
				pssu_pkg::PH_WAIT: begin
					dec_count_d = dec_inc;
					if (dec_inc >= cfg.sample_divider) begin
						dec_count_d = '0;
						hist_shift = 1'b1;
						if (a0 > band_hi && a1 > band_hi && a2 > band_hi
							&& a1 < a0 && a1 < a2) begin
							phase_d = pssu_pkg::PH_POS_LOAD_A;
						end
						if (a0 < band_lo && a1 < band_lo && a2 < band_lo
							&& a1 > a0 && a1 > a2) begin
							phase_d = pssu_pkg::PH_NEG_LOAD_A;
						end
						if (a0 > band_lo && a0 < band_hi
							&& a1 > band_lo && a1 < band_hi) begin
							phase_d = pssu_pkg::PH_BALANCE;
							clr = 1'b1;
						end
					end
				end
				pssu_pkg::PH_POS_LOAD_A, pssu_pkg::PH_NEG_LOAD_B: begin
					wr = 1'b1;
					dv = kick_pos;
					kick_count_d = cfg.kick_ticks;
					phase_d = phase_q + 1'b1;
				end
				pssu_pkg::PH_POS_LOAD_B, pssu_pkg::PH_NEG_LOAD_A: begin
					wr = 1'b1;
					dv = kick_neg;
					kick_count_d = cfg.kick_ticks;
					phase_d = phase_q + 1'b1;
				end
				pssu_pkg::PH_POS_HOLD_A, pssu_pkg::PH_NEG_HOLD_A: begin
					kick_count_d = kick_dec;
					if (kick_dec == '0) begin
						phase_d = phase_q + 1'b1;
					end
				end
				pssu_pkg::PH_POS_HOLD_B, pssu_pkg::PH_NEG_HOLD_B: begin
					kick_count_d = kick_dec;
					if (kick_dec == '0) begin
						wr = 1'b1;
						phase_d = pssu_pkg::PH_WAIT;
					end
				end
				pssu_pkg::PH_BALANCE: begin
					if (!(a0 < band_hi && a0 > band_lo)) begin
						phase_d = pssu_pkg::PH_STOP;
					end
				end
				default: begin
					phase_d = pssu_pkg::PH_STOP;
					wr = 1'b1;
				end
			endcase
		end

		result.drive_write = wr;
		result.drive_value = dv;
		result.phase_code = phase_d;
		result.balance_active = (phase_d == pssu_pkg::PH_BALANCE);
		result.balance_clear = clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pssu_pkg::PH_STOP;
			dec_count_q <= '0;
			kick_count_q <= '0;
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			dec_count_q <= dec_count_d;
			kick_count_q <= kick_count_d;
			if (hist_shift) begin
				hist_q[0] <= item.angle_sample;
				hist_q[1] <= hist_q[0];
				hist_q[2] <= hist_q[1];
			end
		end
	end

endmodule

// ----- rtl/core/pendulum_swing_up_sequencer_unit.sv -----
// Top level of the pendulum swing-up sequencer: input register, sequencer
// core, configuration registers and result register. Depends on pssu_pkg.
//
// Each accepted item (a timer tick with an angle sample, or a start/stop key
// press) gives exactly one result. An item is taken into the input register
// on its transfer; once the result register is free or being emptied, the core
// updates its state and the result register takes the result. While every
// result is taken at once, a new item can be accepted in every cycle; the rate
// is one item per cycle. While a result waits to be taken, one more item can
// be accepted into the input register, and further input transfers stall
// until the result is taken. Configuration writes take effect on the next
// edge and are meant to happen only while no item is in flight.
module pendulum_swing_up_sequencer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pssu_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output pssu_pkg::out_item_t out_item,
	input  logic cfg_write_en,
	input  logic [pssu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pssu_pkg::CFG_DATA_W-1:0] cfg_data
);

	pssu_pkg::cfg_t cfg;
	pssu_pkg::in_item_t item_s1;
	pssu_pkg::out_item_t result;
	pssu_pkg::out_item_t out_item_q;
	logic valid_s1;
	logic out_valid_q;
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_item_q <= result;
		end
	end

	pssu_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	pssu_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// ----- sim/tb_pendulum_swing_up_sequencer_unit.sv -----
// Self-checking testbench for pendulum_swing_up_sequencer_unit: directed and random
// ticks and key presses over many register settings, checked against an in-bench model.
// Depends on pssu_pkg and the sequencer RTL only.
module tb_pendulum_swing_up_sequencer_unit;

	typedef enum int {ANY_ANGLE, ABOVE_BAND, BELOW_BAND, IN_WINDOW, ON_EDGE} angle_zone_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pssu_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pssu_pkg::out_item_t out_item;
	logic cfg_write_en = 1'b0;
	logic [pssu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [pssu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int tx_idle_pct = 24;
	int rx_idle_pct = 88;
	int mismatch_count = 0;
	pssu_pkg::out_item_t drive_cmd_q[$];

	logic [pssu_pkg::ANGLE_W-1:0] cfg_center = pssu_pkg::RST_UPRIGHT_ANGLE;
	logic [pssu_pkg::RANGE_W-1:0] cfg_range = pssu_pkg::RST_CAPTURE_RANGE;
	logic [pssu_pkg::DRIVE_W-1:0] cfg_kick_drive = pssu_pkg::RST_KICK_DRIVE;
	logic [pssu_pkg::COUNT_W-1:0] cfg_kick_ticks = pssu_pkg::RST_KICK_TICKS;
	logic [pssu_pkg::COUNT_W-1:0] cfg_divider = pssu_pkg::RST_SAMPLE_DIVIDER;

	logic [pssu_pkg::PHASE_W-1:0] sw_phase = pssu_pkg::PH_STOP;
	logic [pssu_pkg::COUNT_W-1:0] sw_decim = '0;
	logic [pssu_pkg::COUNT_W-1:0] sw_kick = '0;
	logic [pssu_pkg::ANGLE_W-1:0] sw_hist [3] = '{default: '0};

	pendulum_swing_up_sequencer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic pssu_pkg::out_item_t advance_swing_state(input pssu_pkg::in_item_t it);
		pssu_pkg::out_item_t res;
		int hi_band, lo_band, mag, ang, a0, a1, a2;
		res = '0;
		hi_band = int'(cfg_center) + int'(cfg_range);
		lo_band = int'(cfg_center) - int'(cfg_range);
		mag = (cfg_kick_drive > pssu_pkg::DRIVE_LIMIT) ? int'(pssu_pkg::DRIVE_LIMIT)
			: int'(cfg_kick_drive);
		ang = int'(it.angle_sample);
		if (it.mode) begin
			sw_phase = (sw_phase == pssu_pkg::PH_STOP) ? pssu_pkg::PH_POS_LOAD_A
				: pssu_pkg::PH_STOP;
		end else begin
			case (sw_phase)
			pssu_pkg::PH_WAIT: begin
				sw_decim = sw_decim + 16'd1;
				if (sw_decim >= cfg_divider) begin
					sw_decim = '0;
					sw_hist[2] = sw_hist[1];
					sw_hist[1] = sw_hist[0];
					sw_hist[0] = it.angle_sample;
					a0 = int'(sw_hist[0]);
					a1 = int'(sw_hist[1]);
					a2 = int'(sw_hist[2]);
					if (a0 > hi_band && a1 > hi_band && a2 > hi_band && a1 < a0 && a1 < a2)
						sw_phase = pssu_pkg::PH_POS_LOAD_A;
					if (a0 < lo_band && a1 < lo_band && a2 < lo_band && a1 > a0 && a1 > a2)
						sw_phase = pssu_pkg::PH_NEG_LOAD_A;
					if (a0 > lo_band && a0 < hi_band && a1 > lo_band && a1 < hi_band) begin
						sw_phase = pssu_pkg::PH_BALANCE;
						res.balance_clear = 1'b1;
					end
				end
			end
			pssu_pkg::PH_POS_LOAD_A, pssu_pkg::PH_POS_LOAD_B,
			pssu_pkg::PH_NEG_LOAD_A, pssu_pkg::PH_NEG_LOAD_B: begin
				res.drive_write = 1'b1;
				res.drive_value = (sw_phase == pssu_pkg::PH_POS_LOAD_A
					|| sw_phase == pssu_pkg::PH_NEG_LOAD_B) ? 8'(mag) : 8'(-mag);
				sw_kick = cfg_kick_ticks;
				sw_phase = sw_phase + 4'd1;
			end
			pssu_pkg::PH_POS_HOLD_A, pssu_pkg::PH_POS_HOLD_B,
			pssu_pkg::PH_NEG_HOLD_A, pssu_pkg::PH_NEG_HOLD_B: begin
				sw_kick = sw_kick - 16'd1;
				if (sw_kick == '0) begin
					if (sw_phase == pssu_pkg::PH_POS_HOLD_B
						|| sw_phase == pssu_pkg::PH_NEG_HOLD_B) begin
						res.drive_write = 1'b1;
						sw_phase = pssu_pkg::PH_WAIT;
					end else begin
						sw_phase = sw_phase + 4'd1;
					end
				end
			end
			pssu_pkg::PH_BALANCE: begin
				if (!(ang < hi_band && ang > lo_band))
					sw_phase = pssu_pkg::PH_STOP;
			end
			default: begin
				sw_phase = pssu_pkg::PH_STOP;
				res.drive_write = 1'b1;
			end
			endcase
		end
		res.phase_code = sw_phase;
		res.balance_active = (sw_phase == pssu_pkg::PH_BALANCE);
		return res;
	endfunction

	function automatic logic [pssu_pkg::ANGLE_W-1:0] pick_angle(input angle_zone_t zone);
		int hi_band, lo_band, lo_lim, hi_lim, pick, offset;
		hi_band = int'(cfg_center) + int'(cfg_range);
		lo_band = int'(cfg_center) - int'(cfg_range);
		pick = $urandom_range(4095);
		case (zone)
		ABOVE_BAND: begin
			if (hi_band < 4095)
				pick = $urandom_range(4095, hi_band + 1);
		end
		BELOW_BAND: begin
			if (lo_band > 0)
				pick = $urandom_range(lo_band - 1, 0);
		end
		IN_WINDOW: begin
			lo_lim = (lo_band + 1 < 0) ? 0 : lo_band + 1;
			hi_lim = (hi_band - 1 > 4095) ? 4095 : hi_band - 1;
			if (lo_lim <= hi_lim)
				pick = $urandom_range(hi_lim, lo_lim);
		end
		ON_EDGE: begin
			offset = $urandom_range(2);
			pick = ($urandom_range(1) ? hi_band : lo_band) + offset - 1;
			if (pick < 0)
				pick = 0;
			if (pick > 4095)
				pick = 4095;
		end
		default: ;
		endcase
		return pick[pssu_pkg::ANGLE_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : result_check
		pssu_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_cmd_q.size() == 0) begin
				report_mismatch($sformatf("result transfer with nothing expected: %p", out_item));
			end else begin
				want = drive_cmd_q.pop_front();
				if (out_item.drive_write !== want.drive_write)
					report_mismatch($sformatf("drive_write %0b, expected %0b",
						out_item.drive_write, want.drive_write));
				if (out_item.drive_value !== want.drive_value)
					report_mismatch($sformatf("drive_value %0d, expected %0d",
						out_item.drive_value, want.drive_value));
				if (out_item.phase_code !== want.phase_code)
					report_mismatch($sformatf("phase_code %0d, expected %0d",
						out_item.phase_code, want.phase_code));
				if (out_item.balance_active !== want.balance_active)
					report_mismatch($sformatf("balance_active %0b, expected %0b",
						out_item.balance_active, want.balance_active));
				if (out_item.balance_clear !== want.balance_clear)
					report_mismatch($sformatf("balance_clear %0b, expected %0b",
						out_item.balance_clear, want.balance_clear));
			end
		end
	end

	task automatic send_item(input pssu_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		drive_cmd_q.push_back(advance_swing_state(it));
	endtask

	task automatic send_tick(input logic [pssu_pkg::ANGLE_W-1:0] angle);
		pssu_pkg::in_item_t it;
		it.mode = 1'b0;
		it.angle_sample = angle;
		send_item(it);
	endtask

	task automatic send_press();
		pssu_pkg::in_item_t it;
		it.mode = 1'b1;
		it.angle_sample = 12'($urandom_range(4095));
		send_item(it);
	endtask

	// Holds off new transfers until every expected result has been taken.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_cmd_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pssu_pkg::CFG_INDEX_W-1:0] idx, input int value);
		logic [pssu_pkg::CFG_DATA_W-1:0] data;
		data = value[pssu_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
		pssu_pkg::CFG_UPRIGHT_ANGLE: cfg_center = data[pssu_pkg::ANGLE_W-1:0];
		pssu_pkg::CFG_CAPTURE_RANGE: cfg_range = data[pssu_pkg::RANGE_W-1:0];
		pssu_pkg::CFG_KICK_DRIVE: cfg_kick_drive = data[pssu_pkg::DRIVE_W-1:0];
		pssu_pkg::CFG_KICK_TICKS: cfg_kick_ticks = data;
		pssu_pkg::CFG_SAMPLE_DIVIDER: cfg_divider = data;
		default: ;
		endcase
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic write_random_settings(input int sel);
		int val;
		if (sel == 0) begin
			write_reg(pssu_pkg::CFG_UPRIGHT_ANGLE, 0);
			write_reg(pssu_pkg::CFG_CAPTURE_RANGE, 0);
			write_reg(pssu_pkg::CFG_KICK_DRIVE, 0);
			write_reg(pssu_pkg::CFG_KICK_TICKS, 1);
			write_reg(pssu_pkg::CFG_SAMPLE_DIVIDER, 0);
		end else if (sel == 1) begin
			write_reg(pssu_pkg::CFG_UPRIGHT_ANGLE, 4095);
			write_reg(pssu_pkg::CFG_CAPTURE_RANGE, 2047);
			write_reg(pssu_pkg::CFG_KICK_DRIVE, 127);
			write_reg(pssu_pkg::CFG_KICK_TICKS, 4);
			write_reg(pssu_pkg::CFG_SAMPLE_DIVIDER, 3);
		end else begin
			case ($urandom_range(5))
			0: val = 0;
			1: val = 4095;
			default: val = $urandom_range(4095);
			endcase
			write_reg(pssu_pkg::CFG_UPRIGHT_ANGLE, val);
			case ($urandom_range(5))
			0: val = 0;
			1: val = 2047;
			default: val = $urandom_range(900, 50);
			endcase
			write_reg(pssu_pkg::CFG_CAPTURE_RANGE, val);
			case ($urandom_range(5))
			0: val = 100;
			1: val = 127;
			default: val = $urandom_range(127);
			endcase
			write_reg(pssu_pkg::CFG_KICK_DRIVE, val);
			write_reg(pssu_pkg::CFG_KICK_TICKS, $urandom_range(4, 1));
			write_reg(pssu_pkg::CFG_SAMPLE_DIVIDER, $urandom_range(3, 0));
		end
	endtask

	task automatic run_swing_traffic(input int count);
		angle_zone_t zone;
		pssu_pkg::in_item_t it;
		int pick;
		zone = IN_WINDOW;
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				pick = $urandom_range(99);
				zone = (pick < 10) ? ANY_ANGLE : (pick < 35) ? ABOVE_BAND :
					(pick < 60) ? BELOW_BAND : (pick < 90) ? IN_WINDOW : ON_EDGE;
			end
			if (sw_phase == pssu_pkg::PH_STOP)
				it.mode = ($urandom_range(9) < 4);
			else
				it.mode = ($urandom_range(49) == 0);
			it.angle_sample = pick_angle(zone);
			send_item(it);
		end
	endtask

	// Reset register values: one full kick, then the slow history sampling into balance.
	task automatic test_reset_settings();
		send_tick(pick_angle(ANY_ANGLE));
		send_press();
		repeat (290) send_tick(pick_angle(IN_WINDOW));
		repeat (5) send_tick(pick_angle(ABOVE_BAND));
	endtask

	// Short kicks with a saturated drive, sampling on every tick, then valley, peak
	// and centre captures with the window edges hit exactly.
	task automatic test_directed_edges();
		wait_idle();
		write_reg(pssu_pkg::CFG_UPRIGHT_ANGLE, 2048);
		write_reg(pssu_pkg::CFG_CAPTURE_RANGE, 300);
		write_reg(pssu_pkg::CFG_KICK_DRIVE, 127);
		write_reg(pssu_pkg::CFG_KICK_TICKS, 1);
		write_reg(pssu_pkg::CFG_SAMPLE_DIVIDER, 0);
		if (sw_phase != pssu_pkg::PH_STOP)
			send_press();
		send_tick(12'd0);
		send_press();
		repeat (4) send_tick(12'd4095);
		send_tick(12'd4095);
		send_tick(12'd4000);
		send_tick(12'd4095);
		repeat (4) send_tick(12'd2048);
		send_tick(12'd0);
		send_tick(12'd100);
		send_tick(12'd0);
		repeat (4) send_tick(12'd2048);
		send_tick(12'd1748);
		send_tick(12'd1749);
		send_tick(12'd2347);
		send_tick(12'd2048);
		send_tick(12'd2348);
		send_press();
		send_tick(12'd2048);
		send_press();
	endtask

	task automatic test_random_settings(input int blocks, input int count);
		for (int b = 0; b < blocks; b++) begin
			wait_idle();
			write_random_settings(b);
			run_swing_traffic(count);
		end
	endtask

	// A zero kick time makes the hold counter wrap, so the first hold keeps going
	// long after one tick, and the largest divider is loaded.
	task automatic test_counter_wrap();
		wait_idle();
		write_reg(pssu_pkg::CFG_UPRIGHT_ANGLE, 2025);
		write_reg(pssu_pkg::CFG_CAPTURE_RANGE, 500);
		write_reg(pssu_pkg::CFG_KICK_DRIVE, 60);
		write_reg(pssu_pkg::CFG_KICK_TICKS, 0);
		write_reg(pssu_pkg::CFG_SAMPLE_DIVIDER, 65535);
		if (sw_phase != pssu_pkg::PH_STOP)
			send_press();
		send_press();
		repeat (20) send_tick(pick_angle(IN_WINDOW));
		send_press();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_settings();
		test_directed_edges();
		test_random_settings(3, 90);
		tx_idle_pct = 88;
		rx_idle_pct = 24;
		test_random_settings(3, 90);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_settings(3, 90);
		test_counter_wrap();
		wait_idle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
